/* rtl/ftt_pkg.sv */
// Shared types, constants and helper functions for the flow TTL table.
// Used by every module of the block except ftt_ram; depends on nothing.
package ftt_pkg;

    // Table geometry (entries must be a power of two: the index is the low bits)
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;

    // Field widths
    localparam int ACT_W   = 2;
    localparam int PROTO_W = 8;
    localparam int TTL_W   = 7;
    localparam int VERD_W  = 2;
    localparam int FLOW_W  = 10;
    localparam int AGED_W  = 11;

    // Actions
    localparam logic [ACT_W-1:0] ACT_OUT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_IN   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;

    // Protocol numbers
    localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
    localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;

    // Verdicts
    localparam logic [VERD_W-1:0] V_PASS   = 2'd0;
    localparam logic [VERD_W-1:0] V_NEWTTL = 2'd1;
    localparam logic [VERD_W-1:0] V_DROP   = 2'd2;
    localparam logic [VERD_W-1:0] V_TICK   = 2'd3;

    localparam logic [TTL_W-1:0] TTL_FLOOR = 7'd10;

    // Request and response payloads
    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [31:0]        src_ip;
        logic [31:0]        dest_ip;
        logic [15:0]        src_port;
        logic [15:0]        dst_port;
        logic [PROTO_W-1:0] protocol;
        logic               fin_flag;
        logic [7:0]         random_byte;
    } req_t;

    typedef struct packed {
        logic [VERD_W-1:0] verdict;
        logic [TTL_W-1:0]  new_ttl;
        logic [FLOW_W-1:0] flow_index;
        logic [AGED_W-1:0] aged_count;
    } rsp_t;

    // Table entries
    typedef struct packed {
        logic             valid;
        logic [TTL_W-1:0] ttl;
    } tcp_ent_t;

    typedef struct packed {
        logic             valid;
        logic             active;
        logic [TTL_W-1:0] ttl;
    } udp_ent_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_req;   // latch the request on accept
        logic rd_port;    // read address from the request port
        logic rd_sweep;   // read address from the sweep counter
        logic cnt_clr;    // zero the sweep counter and aged count
        logic cnt_inc;    // advance the sweep counter
        logic clr_wr;     // write empty entries at the sweep counter
        logic age_wr;     // write back the aged entry behind the counter
        logic pkt_wr;     // packet read-modify-write and response load
        logic age_done;   // tick response load and phase flip
    } ftt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic req_tick;
        logic cnt_zero;
        logic cnt_last;
        logic cnt_end;
        logic slot_free;
    } ftt_sts_t;

    // Flow index: ((sip | dip) & (sp | dp)) | proto, low bits
    function automatic logic [IDX_W-1:0] flow_idx(req_t r);
        logic [31:0] h;
        h = ((r.src_ip | r.dest_ip) & {16'd0, r.src_port | r.dst_port})
            | {24'd0, r.protocol};
        return h[IDX_W-1:0];
    endfunction

    // New TTL from a random byte, lifted to at least the floor
    function automatic logic [TTL_W-1:0] fresh_ttl(logic [7:0] rnd);
        logic [TTL_W-1:0] t;
        t = rnd[TTL_W-1:0];
        if (t < TTL_FLOOR)
            t = t + TTL_FLOOR;
        return t;
    endfunction

endpackage

/* rtl/ftt_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependency.
module ftt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ftt_ctrl.sv */
// Sequencer for the flow TTL table: clearing pass, packet update, aging sweep.
// Depends on ftt_pkg for command and status types.
module ftt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ftt_pkg::ftt_sts_t sts,
    output ftt_pkg::ftt_cmd_t cmd
);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_AGE  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLR:
            begin
                cmd.clr_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (sts.cnt_last)
                begin
                    cmd.cnt_inc = 1'b0;
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.rd_port = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    if (sts.req_tick)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = ST_AGE;
                    end
                    else
                    begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD:
            begin
                // entry data is held until the response slot frees up
                if (sts.slot_free)
                begin
                    cmd.pkt_wr = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_AGE:
            begin
                // read entry n while writing back entry n-1
                cmd.rd_sweep = 1'b1;
                cmd.age_wr   = !sts.cnt_zero;
                cmd.cnt_inc  = !sts.cnt_end;
                if (sts.cnt_end)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (sts.slot_free)
                begin
                    cmd.age_done = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLR;
            end
        endcase
    end

endmodule

/* rtl/ftt_dp.sv */
// Datapath of the flow TTL table: request latch, entry RAMs, sweep counter,
// aging logic and response register. Depends on ftt_pkg and ftt_ram.
module ftt_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  ftt_pkg::req_t     req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ftt_pkg::rsp_t     rsp,
    input  ftt_pkg::ftt_cmd_t cmd,
    output ftt_pkg::ftt_sts_t sts
);

    localparam int TCP_W = $bits(ftt_pkg::tcp_ent_t);
    localparam int UDP_W = $bits(ftt_pkg::udp_ent_t);

    ftt_pkg::req_t                   req_reg;
    logic [ftt_pkg::IDX_W-1:0]       idx_reg;
    logic [ftt_pkg::CNT_W-1:0]       cnt_reg;
    logic [ftt_pkg::CNT_W-1:0]       aged_reg;
    logic                            phase_reg;
    logic                            out_valid_reg;
    ftt_pkg::rsp_t                   out_reg;

    logic [ftt_pkg::IDX_W-1:0]       port_idx;
    logic [ftt_pkg::IDX_W-1:0]       cnt_idx;
    logic [ftt_pkg::IDX_W-1:0]       prev_idx;
    logic [ftt_pkg::IDX_W-1:0]       rd_addr;

    ftt_pkg::tcp_ent_t               tcp_rd;
    ftt_pkg::tcp_ent_t               tcp_wdata;
    logic                            tcp_we;
    logic [ftt_pkg::IDX_W-1:0]       tcp_waddr;

    ftt_pkg::udp_ent_t               udp_rd;
    ftt_pkg::udp_ent_t               udp_wdata;
    ftt_pkg::udp_ent_t               age_ent;
    logic                            udp_we;
    logic [ftt_pkg::IDX_W-1:0]       udp_waddr;

    logic                            is_out;
    logic                            is_in;
    logic                            tcp_go;
    logic                            udp_go;
    logic [ftt_pkg::TTL_W-1:0]       new_ttl;
    logic [ftt_pkg::TTL_W-1:0]       tcp_ttl;
    logic [ftt_pkg::TTL_W-1:0]       udp_ttl;
    logic                            age_hit;
    logic [31:0]                     idx_ext;
    logic [31:0]                     aged_ext;
    ftt_pkg::rsp_t                   pkt_rsp;
    ftt_pkg::rsp_t                   tick_rsp;

    assign port_idx = ftt_pkg::flow_idx(req);
    assign cnt_idx  = cnt_reg[ftt_pkg::IDX_W-1:0];
    assign prev_idx = cnt_idx - ftt_pkg::IDX_W'(1);

    // Status to controller
    assign sts.req_tick  = (req.action == ftt_pkg::ACT_TICK);
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.cnt_last  = (cnt_reg == ftt_pkg::CNT_W'(ftt_pkg::TABLE_ENTRIES - 1));
    assign sts.cnt_end   = (cnt_reg == ftt_pkg::CNT_W'(ftt_pkg::TABLE_ENTRIES));
    assign sts.slot_free = !out_valid_reg || !rsp_stall;

    // Request latch
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
            idx_reg <= port_idx;
        end
    end

    // Sweep counter, aged count, aging phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            aged_reg  <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clr)
            begin
                cnt_reg  <= '0;
                aged_reg <= '0;
            end
            else
            begin
                if (cmd.cnt_inc)
                begin
                    cnt_reg <= cnt_reg + ftt_pkg::CNT_W'(1);
                end
                if (cmd.age_wr && age_hit)
                begin
                    aged_reg <= aged_reg + ftt_pkg::CNT_W'(1);
                end
            end
            if (cmd.age_done)
            begin
                phase_reg <= !phase_reg;
            end
        end
    end

    // Shared read address for both tables
    always_comb
    begin
        priority if (cmd.rd_port)
            rd_addr = port_idx;
        else if (cmd.rd_sweep)
            rd_addr = cnt_idx;
        else
            rd_addr = idx_reg;
    end

    // Packet decode
    assign is_out  = (req_reg.action == ftt_pkg::ACT_OUT);
    assign is_in   = (req_reg.action == ftt_pkg::ACT_IN);
    assign tcp_go  = is_out && (req_reg.protocol == ftt_pkg::PROTO_TCP);
    assign udp_go  = is_in && (req_reg.protocol == ftt_pkg::PROTO_UDP);
    assign new_ttl = ftt_pkg::fresh_ttl(req_reg.random_byte);
    assign tcp_ttl = tcp_rd.valid ? tcp_rd.ttl : new_ttl;
    assign udp_ttl = udp_rd.valid ? udp_rd.ttl : new_ttl;
    assign idx_ext = 32'(idx_reg);

    // Packet response
    always_comb
    begin
        pkt_rsp            = '0;
        pkt_rsp.verdict    = ftt_pkg::V_PASS;
        pkt_rsp.flow_index = (is_out || is_in) ? idx_ext[ftt_pkg::FLOW_W-1:0] : '0;
        priority if (tcp_go)
        begin
            pkt_rsp.verdict = ftt_pkg::V_NEWTTL;
            pkt_rsp.new_ttl = tcp_ttl;
        end
        else if (udp_go)
        begin
            pkt_rsp.verdict = ftt_pkg::V_NEWTTL;
            pkt_rsp.new_ttl = udp_ttl;
        end
        else if (is_out && req_reg.protocol != ftt_pkg::PROTO_ICMP
                 && req_reg.protocol != ftt_pkg::PROTO_UDP)
        begin
            pkt_rsp.verdict = ftt_pkg::V_DROP;
        end
        else if (is_in && req_reg.protocol != ftt_pkg::PROTO_ICMP
                 && req_reg.protocol != ftt_pkg::PROTO_TCP)
        begin
            pkt_rsp.verdict = ftt_pkg::V_DROP;
        end
        else
        begin
            pkt_rsp.verdict = ftt_pkg::V_PASS;
        end
    end

    // Aging of the entry read last cycle
    always_comb
    begin
        age_ent = udp_rd;
        if (!phase_reg)
        begin
            age_hit        = udp_rd.valid;
            age_ent.active = 1'b0;
        end
        else
        begin
            age_hit       = udp_rd.valid && !udp_rd.active;
            age_ent.valid = udp_rd.valid && udp_rd.active;
        end
    end

    // Tick response
    assign aged_ext = 32'(aged_reg);
    always_comb
    begin
        tick_rsp            = '0;
        tick_rsp.verdict    = ftt_pkg::V_TICK;
        tick_rsp.aged_count = aged_ext[ftt_pkg::AGED_W-1:0];
    end

    // TCP table write port; FIN removes the entry after use
    assign tcp_we          = cmd.clr_wr || (cmd.pkt_wr && tcp_go);
    assign tcp_waddr       = cmd.clr_wr ? cnt_idx : idx_reg;
    assign tcp_wdata.valid = !cmd.clr_wr && !req_reg.fin_flag;
    assign tcp_wdata.ttl   = cmd.clr_wr ? '0 : tcp_ttl;

    // UDP table write port
    assign udp_we = cmd.clr_wr || cmd.age_wr || (cmd.pkt_wr && udp_go);
    always_comb
    begin
        priority if (cmd.clr_wr)
        begin
            udp_waddr = cnt_idx;
            udp_wdata = '0;
        end
        else if (cmd.age_wr)
        begin
            udp_waddr = prev_idx;
            udp_wdata = age_ent;
        end
        else
        begin
            udp_waddr        = idx_reg;
            udp_wdata.valid  = 1'b1;
            udp_wdata.active = 1'b1;
            udp_wdata.ttl    = udp_ttl;
        end
    end

    ftt_ram #(
        .WIDTH(TCP_W),
        .DEPTH(ftt_pkg::TABLE_ENTRIES)
    ) u_tcp_ram (
        .clk  (clk),
        .we   (tcp_we),
        .waddr(tcp_waddr),
        .wdata(tcp_wdata),
        .raddr(rd_addr),
        .rdata(tcp_rd)
    );

    ftt_ram #(
        .WIDTH(UDP_W),
        .DEPTH(ftt_pkg::TABLE_ENTRIES)
    ) u_udp_ram (
        .clk  (clk),
        .we   (udp_we),
        .waddr(udp_waddr),
        .wdata(udp_wdata),
        .raddr(rd_addr),
        .rdata(udp_rd)
    );

    // Response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.pkt_wr || cmd.age_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (cmd.pkt_wr)
        begin
            out_reg <= pkt_rsp;
        end
        else if (cmd.age_done)
        begin
            out_reg <= tick_rsp;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

/* rtl/flow_ttl_table_with_aging.sv */
// Flow TTL table with two-phase aging: a packet is accepted, then its entry
// in the TCP or UDP table RAM gets one read-modify-write. An aging tick
// sweeps the UDP table RAM one entry per cycle. After reset a clearing pass
// empties both tables while req_stall stays high. The flow index is the low
// bits of the hash, so TABLE_ENTRIES is a power of two. One response comes
// back per request; a finished response waits in the output register while
// the next request is taken.
module flow_ttl_table_with_aging (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ftt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ftt_pkg::rsp_t rsp
);

    ftt_pkg::ftt_cmd_t cmd;
    ftt_pkg::ftt_sts_t sts;

    ftt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ftt_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

/* rtl/ftt_chk.sv */
// Port-level checks for the flow TTL table, bound to the top level.
// Depends on ftt_pkg for payload types and verdict codes.
module ftt_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input ftt_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input ftt_pkg::rsp_t rsp
);

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // One request at a time: stall rises right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second request taken while one is in work");

    // Tick responses carry only the aged count
    a_tick_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.verdict == ftt_pkg::V_TICK |->
            rsp.new_ttl == '0 && rsp.flow_index == '0)
        else $error("tick response with packet fields");

    // Packet responses carry no aged count
    a_pkt_aged: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.verdict != ftt_pkg::V_TICK |-> rsp.aged_count == '0)
        else $error("packet response with aged count");

    // A handed-out TTL is never below the floor
    a_ttl_floor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.verdict == ftt_pkg::V_NEWTTL |-> rsp.new_ttl >= ftt_pkg::TTL_FLOOR)
        else $error("TTL below floor");

endmodule

bind flow_ttl_table_with_aging ftt_chk u_ftt_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
);
